// ----- rtl/core/vfp_pkg.sv -----
// vfp_pkg: shared constants, parse phase encoding and result struct for
// the vision frame parser. No dependencies.
package vfp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int WINDOW_LEN  = 5;

  localparam logic [7:0] HDR_BYTE      = 8'hAA;
  localparam logic [7:0] FUNC_LIMIT    = 8'hFF;
  localparam logic [7:0] FUNC_POSITION = 8'hF2;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_FUNC    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  typedef struct packed {
    logic               valid;
    logic [7:0]         frame_func;
    logic               position_update;
    logic signed [15:0] dot_x;
    logic signed [15:0] dot_y;
    logic [7:0]         dot_flag;
  } result_t;

endpackage

// ----- rtl/core/vfp_parse.sv -----
// vfp_parse: byte-wide frame state machine with the five-byte position
// window. Produces a combinational result for the byte being accepted.
// Depends on vfp_pkg.
module vfp_parse
  import vfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output phase_t     phase,
  output result_t    res
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       win_r   [WINDOW_LEN];
  logic [7:0]       win_nxt [WINDOW_LEN];
  logic             win_we;
  logic             pos;

  assign phase = phase_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_r)
        PH_HUNT1:   phase_nxt = (rx_byte == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
        PH_HUNT2:   phase_nxt = (rx_byte == HDR_BYTE) ? PH_FUNC : PH_HUNT1;
        PH_FUNC:    phase_nxt = (rx_byte < FUNC_LIMIT) ? PH_LEN : PH_HUNT1;
        PH_LEN:     phase_nxt = ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD)) ? PH_PAYLOAD
                                                                     : PH_HUNT1;
        PH_PAYLOAD: begin
          if (rem_r == '0) begin
            phase_nxt = PH_HUNT1;   // zero length: frame dropped
          end else if (rem_r == CNT_W'(1)) begin
            phase_nxt = PH_TRAILER;
          end
        end
        PH_TRAILER: phase_nxt = PH_HUNT1;
        default:    phase_nxt = PH_HUNT1;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    rem_nxt  = rem_r;
    idx_nxt  = idx_r;
    func_nxt = func_r;
    win_we   = 1'b0;
    res      = '0;
    if (accept) begin
      case (phase_r)
        PH_FUNC: begin
          if (rx_byte < FUNC_LIMIT) begin
            func_nxt = rx_byte;
          end
        end
        PH_LEN: begin
          if ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD)) begin
            rem_nxt = rx_byte[CNT_W-1:0];
            idx_nxt = '0;
          end
        end
        PH_PAYLOAD: begin
          if (rem_r != '0) begin
            rem_nxt = rem_r - CNT_W'(1);
            idx_nxt = idx_r + CNT_W'(1);
            win_we  = 1'b1;
          end
        end
        PH_TRAILER: begin
          win_we    = 1'b1;
          res.valid = 1'b1;
        end
        default: ;
      endcase
    end
    // bytes beyond the window are dropped
    for (int i = 0; i < WINDOW_LEN; i++) begin
      win_nxt[i] = (win_we && idx_r == CNT_W'(i)) ? rx_byte : win_r[i];
    end
    // the trailer itself may land in the window before the fields are read
    pos                 = (func_r == FUNC_POSITION);
    res.frame_func      = func_r;
    res.position_update = pos;
    res.dot_x           = pos ? {win_nxt[0], win_nxt[1]} : 16'sd0;
    res.dot_y           = pos ? {win_nxt[2], win_nxt[3]} : 16'sd0;
    res.dot_flag        = pos ? win_nxt[4] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      rem_r   <= '0;
      idx_r   <= '0;
      func_r  <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
      func_r  <= func_nxt;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  a_res_only_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (accept && phase_r == PH_TRAILER))
    else $error("result outside trailer phase");

  a_trailer_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TRAILER) |-> (rem_r == '0))
    else $error("trailer reached with payload outstanding");

  a_payload_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |->
      ({1'b0, idx_r} + {1'b0, rem_r} <= (CNT_W + 1)'(MAX_PAYLOAD)))
    else $error("payload count exceeds maximum length");

endmodule

// ----- rtl/core/vision_frame_parser.sv -----
// vision_frame_parser: one byte per cycle while in_stall is low; a
// result appears on out_* in the cycle after the trailer byte is
// accepted and is held until taken.
// in_stall rises only when a result is waiting under out_stall and the
// next byte is a trailer. Synchronous active-low reset returns the parser
// to header hunting with counters, function code and window cleared.
module vision_frame_parser
  import vfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_func,
  output logic               out_position_update,
  output logic signed [15:0] out_dot_x,
  output logic signed [15:0] out_dot_y,
  output logic [7:0]         out_dot_flag
);

  phase_t  phase;
  result_t res;
  result_t out_r;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;

  // only a trailer byte can produce a result
  assign in_stall = out_valid_r && out_stall && (phase == PH_TRAILER);
  assign accept   = in_valid && !in_stall;

  vfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .phase   (phase),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_func      = out_r.frame_func;
  assign out_position_update = out_r.position_update;
  assign out_dot_x           = out_r.dot_x;
  assign out_dot_y           = out_r.dot_y;
  assign out_dot_flag        = out_r.dot_flag;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !res.valid)
    else $error("pending result overwritten");

  a_held_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("pending result dropped");

  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && phase == PH_TRAILER))
    else $error("input stalled without a pending result");

endmodule

// ----- test/vision_frame_parser_test.sv -----
// vision_frame_parser_test: self-checking bench for the vision frame parser.
// Drives bytes with random gaps and random result stalls, and checks every
// result against an in-bench frame predictor. Depends on vfp_pkg and the RTL.
`timescale 1ns / 100ps

module vision_frame_parser_test;
  import vfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 500;

  typedef enum logic {ST_BYTE, ST_DRAIN} stim_kind_t;

  typedef struct packed {
    stim_kind_t kind;
    logic [7:0] data;
  } stim_t;

  typedef struct packed {
    logic [7:0]         func;
    logic               pos;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         flag;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_frame_func;
  logic               out_position_update;
  logic signed [15:0] out_dot_x;
  logic signed [15:0] out_dot_y;
  logic [7:0]         out_dot_flag;

  vision_frame_parser i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_func      (out_frame_func),
    .out_position_update (out_position_update),
    .out_dot_x           (out_dot_x),
    .out_dot_y           (out_dot_y),
    .out_dot_flag        (out_dot_flag)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // stimulus and expectations
  stim_t         pending_q[$];
  frame_result_t frame_results_q[$];
  int            stim_bytes = 0;
  int            bytes_accepted = 0;
  int            frames_checked = 0;
  int            position_frames = 0;
  int            mismatch_count = 0;
  int            idle_cycles = 0;

  // predictor state
  phase_t     parse_ph = PH_HUNT1;
  logic [5:0] remain_cnt = '0;
  logic [5:0] pay_idx = '0;
  logic [7:0] cur_func = '0;
  logic [7:0] win [WINDOW_LEN];

  // handshake and pacing
  logic in_fire = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  logic quiet = 1'b0;
  int   mode_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending_q.push_back('{kind: ST_BYTE, data: b});
    stim_bytes++;
  endtask

  // header, function, length, payload, then trailer (or the dropping byte for length 0)
  task automatic push_frame(input logic [7:0] func, input int len);
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(func);
    push_byte(len[7:0]);
    for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
    push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic store_window(input logic [5:0] slot, input logic [7:0] b);
    if (slot < WINDOW_LEN) win[slot] = b;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    frame_result_t res;
    case (parse_ph)
      PH_HUNT1: parse_ph = (b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
      PH_HUNT2: parse_ph = (b == HDR_BYTE) ? PH_FUNC : PH_HUNT1;
      PH_FUNC: begin
        if (b < FUNC_LIMIT) begin
          cur_func = b;
          parse_ph = PH_LEN;
        end else begin
          parse_ph = PH_HUNT1;
        end
      end
      PH_LEN: begin
        if (b <= MAX_PAYLOAD) begin
          remain_cnt = b[5:0];
          pay_idx = '0;
          parse_ph = PH_PAYLOAD;
        end else begin
          parse_ph = PH_HUNT1;
        end
      end
      PH_PAYLOAD: begin
        if (remain_cnt != 0) begin
          remain_cnt = remain_cnt - 6'd1;
          store_window(pay_idx, b);
          pay_idx = pay_idx + 6'd1;
          if (remain_cnt == 0) parse_ph = PH_TRAILER;
        end else begin
          parse_ph = PH_HUNT1;
        end
      end
      PH_TRAILER: begin
        store_window(pay_idx, b);
        res.func = cur_func;
        res.pos  = (cur_func == FUNC_POSITION);
        res.x    = res.pos ? {win[0], win[1]} : '0;
        res.y    = res.pos ? {win[2], win[3]} : '0;
        res.flag = res.pos ? win[4] : '0;
        frame_results_q.push_back(res);
        parse_ph = PH_HUNT1;
      end
      default: parse_ph = PH_HUNT1;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // alternate between paced stretches and stretches with no idling at all
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      quiet <= ($urandom_range(0, 3) == 0);
      mode_cycles <= $urandom_range(50, 200);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
  end

  // byte driver
  always @(negedge clk) begin
    stim_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // stalled: hold the item
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_q.size() > 0 && pending_q[0].kind == ST_DRAIN) begin
      in_valid <= 1'b0;
      if (frame_results_q.size() == 0) void'(pending_q.pop_front());
    end else if (pending_q.size() > 0) begin
      nxt = pending_q.pop_front();
      in_valid <= 1'b1;
      in_rx_byte <= nxt.data;
      send_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result-side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // monitor: check results first, then predict from the accepted byte
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (!rst_n) begin
      in_fire <= 1'b0;
      parse_ph = PH_HUNT1;
      remain_cnt = '0;
      pay_idx = '0;
      cur_func = '0;
      for (int i = 0; i < WINDOW_LEN; i++) win[i] = '0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got func %h", $time,
                   out_frame_func);
          mismatch_count++;
        end else begin
          exp_r = frame_results_q.pop_front();
          check_field("frame_func", 16'(exp_r.func), 16'(out_frame_func));
          check_field("position_update", 16'(exp_r.pos), 16'(out_position_update));
          check_field("dot_x", exp_r.x, out_dot_x);
          check_field("dot_y", exp_r.y, out_dot_y);
          check_field("dot_flag", 16'(exp_r.flag), 16'(out_dot_flag));
          frames_checked++;
          if (exp_r.pos) position_frames++;
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte);
        bytes_accepted++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int          r;
    int          len;
    logic [7:0]  func;
    logic [7:0]  b;
    logic        drained;

    drained = 1'b0;
    // position frame with extreme coordinates and flag
    push_byte(HDR_BYTE); push_byte(HDR_BYTE); push_byte(FUNC_POSITION); push_byte(8'd5);
    push_byte(8'h80); push_byte(8'h00); push_byte(8'h7F); push_byte(8'hFF);
    push_byte(8'hFF); push_byte(8'h5A);
    // function byte 0xFF breaks the frame
    push_byte(HDR_BYTE); push_byte(HDR_BYTE); push_byte(FUNC_LIMIT);
    // length one past the maximum breaks the frame
    push_byte(HDR_BYTE); push_byte(HDR_BYTE); push_byte(8'h10);
    push_byte(8'(MAX_PAYLOAD + 1));
    // zero length: the following header byte is dropped, not re-examined
    push_byte(HDR_BYTE); push_byte(HDR_BYTE); push_byte(8'h00); push_byte(8'h00);
    push_byte(HDR_BYTE);
    // short position frame: trailer lands in the window, rest is stale
    push_byte(HDR_BYTE); push_byte(HDR_BYTE); push_byte(FUNC_POSITION); push_byte(8'd1);
    push_byte(8'h11); push_byte(8'h22);
    // lowest function code, no position data
    push_frame(8'h00, 2);
    pending_q.push_back('{kind: ST_DRAIN, data: 8'h00});

    while (stim_bytes < RANDOM_BYTES + 35) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        func = $urandom_range(0, 1) ? FUNC_POSITION : 8'($urandom_range(0, 254));
        r = $urandom_range(0, 19);
        if (r == 0) len = 0;
        else if (r < 14) len = $urandom_range(1, 8);
        else if (r < 18) len = $urandom_range(9, MAX_PAYLOAD - 1);
        else len = MAX_PAYLOAD;
        push_frame(func, len);
      end else if (r < 85) begin
        push_byte(HDR_BYTE);
        case ($urandom_range(0, 3))
          0: begin
            b = 8'($urandom_range(0, 254));
            if (b >= HDR_BYTE) b = b + 8'd1;
            push_byte(b);
          end
          1: begin
            push_byte(HDR_BYTE);
            push_byte(FUNC_LIMIT);
          end
          2: begin
            push_byte(HDR_BYTE);
            push_byte(8'($urandom_range(0, 254)));
            push_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
          end
          default: push_frame(FUNC_POSITION, $urandom_range(1, 6));
        endcase
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
      end
      if ((!drained && stim_bytes > RANDOM_BYTES / 2) || $urandom_range(0, 49) == 0) begin
        pending_q.push_back('{kind: ST_DRAIN, data: 8'h00});
        drained = 1'b1;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted < stim_bytes || frame_results_q.size() > 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("sent %0d bytes; checked %0d frames, %0d of them position updates",
             bytes_accepted, frames_checked, position_frames);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/vfp_pkg.sv
rtl/core/vfp_parse.sv
rtl/core/vision_frame_parser.sv
test/vision_frame_parser_test.sv
